@@ src/mbrtu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared types and constants for the Modbus RTU register slave.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [7:0]  FN_READ  = 8'h03;
   localparam logic [7:0]  FN_WRITE = 8'h06;
   localparam logic [15:0] TEMP_REG = 16'd3;
   localparam logic [7:0]  REPLY_ADDRESS_RESET = 8'h01;

   // response byte index: 3 + 2*count payload bytes plus two crc bytes
   localparam int IDX_W = 7;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic [7:0] temperature;
   } req_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_ADDR,
      PH_FUNC,
      PH_REG_HI,
      PH_REG_LO,
      PH_OPND_HI,
      PH_OPND_LO,
      PH_CRC_LO,
      PH_CRC_HI
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_CRC
   } seq_type;

   typedef struct packed {
      logic       clear;
      logic       load;
      logic [7:0] data;
   } crc_ctl_type;

endpackage
`default_nettype wire

@@ src/modbus_rtu_register_slave_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Request bytes are taken one a cycle; the beat that carries the closing crc
// byte starts the response and the request side stays busy until it is queued.
// Each response payload byte is loaded into the serial crc unit, which runs
// eight bit steps before handing back; the two crc bytes go out directly, so
// a read of c registers returns 3+2c payload bytes and a write echo six,
// each followed by the two crc bytes and subject to output stalls.
// Synchronous reset: parser to frame start, register file cleared, address 1.
// ----------------------------------------------------------------------------
// modbus_rtu_register_slave_unit
// Modbus RTU slave answering read holding registers and write single
// register, with the response crc computed by a shared bit-serial unit.
// ----------------------------------------------------------------------------
module modbus_rtu_register_slave_unit #(
   parameter int REG_COUNT = 6
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  mbrtu_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output mbrtu_pkg::rsp_type   rsp_data,
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire [7:0]            csr_wdata
);
   import mbrtu_pkg::*;

   localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

   seq_type          state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [7:0]       reply_ff;
   logic [7:0]       fn_ff, fn_in;
   logic [15:0]      sa_ff, sa_in;
   logic [15:0]      op_ff, op_in;
   logic [7:0]       temp_ff, temp_in;
   logic [7:0]       bc_ff, bc_in;
   logic [IDX_W-1:0] npay_ff, npay_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic [15:0]      rf_ff [REG_COUNT];
   logic             rf_we;
   logic [AW-1:0]    rf_waddr;
   logic [15:0]      rf_wdata;

   crc_ctl_type      crc_ctl;
   logic [15:0]      crc_val;
   logic             crc_busy;

   logic             req_fire;
   logic             out_free;
   logic [IDX_W-1:0] data_j;
   logic [16:0]      rd_addr;
   logic             rd_in_file;
   logic             rd_is_temp;
   logic [15:0]      rd_word;
   logic [7:0]       pay_byte;
   logic [7:0]       cnt8;

   mbrtu_crc u_crc (
      .clock (clock),
      .reset (reset),
      .ctl   (crc_ctl),
      .crc   (crc_val),
      .busy  (crc_busy)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // read data beats: word (idx-3)/2, high byte first
   assign data_j     = idx_ff - IDX_W'(3);
   assign rd_addr    = {1'b0, sa_ff} + 17'(data_j[IDX_W-1:1]);
   assign rd_in_file = rd_addr < 17'(REG_COUNT);
   assign rd_is_temp = rd_addr == {1'b0, TEMP_REG};

   always_comb begin
      rd_word = 16'h0000;
      if (rd_in_file) begin
         rd_word = rd_is_temp ? {8'h00, temp_ff} : rf_ff[rd_addr[AW-1:0]];
      end
   end

   always_comb begin
      pay_byte = data_j[0] ? rd_word[7:0] : rd_word[15:8];
      if (idx_ff == IDX_W'(0)) begin
         pay_byte = reply_ff;
      end else if (idx_ff == IDX_W'(1)) begin
         pay_byte = fn_ff;
      end else if (fn_ff == FN_READ) begin
         if (idx_ff == IDX_W'(2)) begin
            pay_byte = bc_ff;
         end
      end else begin
         case (idx_ff[1:0])
            2'd2:    pay_byte = sa_ff[15:8];
            2'd3:    pay_byte = sa_ff[7:0];
            2'd0:    pay_byte = op_ff[15:8];
            default: pay_byte = op_ff[7:0];
         endcase
      end
   end

   // clamp the read count to the file
   assign cnt8 = (op_ff > 16'(REG_COUNT)) ? 8'(REG_COUNT) : op_ff[7:0];

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      fn_in        = fn_ff;
      sa_in        = sa_ff;
      op_in        = op_ff;
      temp_in      = temp_ff;
      bc_in        = bc_ff;
      npay_in      = npay_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      crc_ctl      = '0;
      rf_we        = 1'b0;
      rf_waddr     = sa_ff[AW-1:0];
      rf_wdata     = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (phase_ff)
                  PH_FUNC: begin
                     fn_in    = req_data.rx_byte;
                     phase_in = (req_data.rx_byte == FN_READ ||
                                 req_data.rx_byte == FN_WRITE) ? PH_REG_HI : PH_ADDR;
                  end
                  PH_REG_HI: begin
                     sa_in    = {req_data.rx_byte, sa_ff[7:0]};
                     phase_in = PH_REG_LO;
                  end
                  PH_REG_LO: begin
                     sa_in    = {sa_ff[15:8], req_data.rx_byte};
                     phase_in = PH_OPND_HI;
                  end
                  PH_OPND_HI: begin
                     op_in    = {req_data.rx_byte, op_ff[7:0]};
                     phase_in = PH_OPND_LO;
                  end
                  PH_OPND_LO: begin
                     op_in    = {op_ff[15:8], req_data.rx_byte};
                     phase_in = PH_CRC_LO;
                  end
                  PH_CRC_LO: begin
                     phase_in = PH_CRC_HI;
                  end
                  PH_CRC_HI: begin
                     phase_in      = PH_ADDR;
                     temp_in       = req_data.temperature;
                     bc_in         = {cnt8[6:0], 1'b0};
                     npay_in       = (fn_ff == FN_READ) ?
                                     IDX_W'(3) + IDX_W'({cnt8[6:0], 1'b0}) : IDX_W'(6);
                     idx_in        = '0;
                     crc_ctl.clear = 1'b1;
                     state_in      = ST_EMIT;
                     rf_we         = (fn_ff != FN_READ) && (sa_ff < 16'(REG_COUNT));
                  end
                  default: begin
                     phase_in = PH_FUNC;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (idx_ff < npay_ff) begin
                  rsp_in       = '{tx_byte: pay_byte, last_byte: 1'b0};
                  crc_ctl.load = 1'b1;
                  crc_ctl.data = pay_byte;
                  state_in     = ST_CRC;
                  // reading the temperature register latches the sensor value
                  if (fn_ff == FN_READ && idx_ff > IDX_W'(2) && rd_in_file && rd_is_temp) begin
                     rf_we    = 1'b1;
                     rf_waddr = rd_addr[AW-1:0];
                     rf_wdata = {8'h00, temp_ff};
                  end
               end else if (idx_ff == npay_ff) begin
                  rsp_in = '{tx_byte: crc_val[7:0], last_byte: 1'b0};
                  idx_in = idx_ff + IDX_W'(1);
               end else begin
                  rsp_in   = '{tx_byte: crc_val[15:8], last_byte: 1'b1};
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CRC: begin
            if (!crc_busy) begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_EMIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_ADDR;
         fn_ff        <= 8'h00;
         sa_ff        <= 16'h0000;
         op_ff        <= 16'h0000;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         npay_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         fn_ff        <= fn_in;
         sa_ff        <= sa_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         npay_ff      <= npay_in;
      end
   end

   always_ff @(posedge clock) begin
      temp_ff <= temp_in;
      bc_ff   <= bc_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reply_ff <= REPLY_ADDRESS_RESET;
      end else if (csr_valid && csr_ready) begin
         reply_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < REG_COUNT; k++) begin
            rf_ff[k] <= 16'h0000;
         end
      end else if (rf_we) begin
         rf_ff[rf_waddr] <= rf_wdata;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // the serial crc unit only runs while the sequencer waits on it
   a_crc_busy_state : assert property (@(posedge clock) disable iff (reset)
      crc_busy |-> state_ff == ST_CRC)
      else $error("crc unit busy outside crc state");

   a_idx_bound : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> idx_ff <= npay_ff + IDX_W'(1))
      else $error("response index past the crc bytes");

   a_last_beat : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && idx_ff > npay_ff) |=>
         (state_ff == ST_IDLE && rsp_valid_ff && rsp_ff.last_byte))
      else $error("closing crc beat not marked last");

   a_no_reload : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled response beat overwritten");

endmodule
`default_nettype wire

@@ src/mbrtu_crc.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbrtu_crc
// Bit-serial CRC-16 (reflected, poly 0xA001): one byte folded in by eight
// passes of a single shift-and-xor step.
// ----------------------------------------------------------------------------
module mbrtu_crc (
   input  wire                      clock,
   input  wire                      reset,
   input  mbrtu_pkg::crc_ctl_type   ctl,
   output logic [15:0]              crc,
   output logic                     busy
);
   import mbrtu_pkg::*;

   logic [15:0] crc_ff, crc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;

   always_comb begin
      crc_in  = crc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (ctl.clear) begin
         crc_in = CRC_INIT;
      end else if (ctl.load) begin
         crc_in  = crc_ff ^ {8'h00, ctl.data};
         cnt_in  = 3'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         crc_in = crc_ff[0] ? ((crc_ff >> 1) ^ CRC_POLY) : (crc_ff >> 1);
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_INIT;
         cnt_ff  <= 3'd0;
         busy_ff <= 1'b0;
      end else begin
         crc_ff  <= crc_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign crc  = crc_ff;
   assign busy = busy_ff;

endmodule
`default_nettype wire

@@ tb/sv/tb_modbus_rtu_register_slave_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_rtu_register_slave_unit
// Drives Modbus RTU request frames into the slave byte by byte and checks
// every response byte against a behavioural model kept in step with the
// accepted request beats. Mostly well-formed read and write frames with
// random content, and some noise, truncated frames, unknown functions and
// corrupted crcs. Both sides idle and stall at random. The reply address
// is changed between traffic phases while the slave is idle.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_register_slave_unit;
   import mbrtu_pkg::*;

   localparam int REG_COUNT     = 6;
   localparam int SETTLE_CYCLES = 150;
   localparam int STALL_LIMIT   = 4000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [7:0] csr_wdata = 8'h00;

   // request beats waiting to be driven
   req_type    send_queue[$];
   // response bytes the slave owes
   rsp_type    reply_bytes_due[$];

   // model of the slave
   logic [7:0]  reply_addr = REPLY_ADDRESS_RESET;
   phase_type   rx_phase   = PH_ADDR;
   logic [7:0]  rx_func    = 8'h00;
   logic [15:0] rx_start   = 16'h0000;
   logic [15:0] rx_operand = 16'h0000;
   logic [15:0] holding [REG_COUNT];

   int  beats_queued   = 0;
   int  beats_accepted = 0;
   int  n_rsp_beats    = 0;
   int  n_read_replies = 0;
   int  n_write_replies = 0;
   int  n_settings     = 0;
   int  errors         = 0;
   int  gap_left       = 0;
   int  stall_left     = 0;
   int  idle_cycles    = 0;
   bit  steady         = 1'b0;
   logic    req_pending;
   rsp_type want_beat;

   modbus_rtu_register_slave_unit #(
      .REG_COUNT (REG_COUNT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic flag_error(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function automatic logic [15:0] crc16_update(logic [15:0] c, logic [7:0] b);
      c ^= {8'h00, b};
      for (int k = 0; k < 8; k++)
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   // advance the model by one accepted request byte
   task automatic absorb_request(req_type r);
      logic [7:0]  b;
      logic [7:0]  reply[$];
      logic [15:0] c;
      logic [15:0] v;
      int unsigned cnt;
      int unsigned ra;
      b = r.rx_byte;
      case (rx_phase)
         PH_FUNC: begin
            rx_func  = b;
            rx_phase = (b == FN_READ || b == FN_WRITE) ? PH_REG_HI : PH_ADDR;
         end
         PH_REG_HI: begin
            rx_start[15:8] = b;
            rx_phase = PH_REG_LO;
         end
         PH_REG_LO: begin
            rx_start[7:0] = b;
            rx_phase = PH_OPND_HI;
         end
         PH_OPND_HI: begin
            rx_operand[15:8] = b;
            rx_phase = PH_OPND_LO;
         end
         PH_OPND_LO: begin
            rx_operand[7:0] = b;
            rx_phase = PH_CRC_LO;
         end
         PH_CRC_LO: rx_phase = PH_CRC_HI;
         PH_CRC_HI: begin
            reply.push_back(reply_addr);
            reply.push_back(rx_func);
            if (rx_func == FN_READ) begin
               cnt = (rx_operand > REG_COUNT) ? REG_COUNT : rx_operand;
               reply.push_back(8'(cnt * 2));
               for (int i = 0; i < cnt; i++) begin
                  v  = 16'h0000;
                  ra = rx_start + i;
                  if (ra < REG_COUNT) begin
                     // temperature register is refreshed on every read
                     if (ra == TEMP_REG)
                        holding[ra] = {8'h00, r.temperature};
                     v = holding[ra];
                  end
                  reply.push_back(v[15:8]);
                  reply.push_back(v[7:0]);
               end
               n_read_replies++;
            end else begin
               if (rx_start < REG_COUNT)
                  holding[rx_start] = rx_operand;
               reply.push_back(rx_start[15:8]);
               reply.push_back(rx_start[7:0]);
               reply.push_back(rx_operand[15:8]);
               reply.push_back(rx_operand[7:0]);
               n_write_replies++;
            end
            c = CRC_INIT;
            foreach (reply[i]) begin
               c = crc16_update(c, reply[i]);
               reply_bytes_due.push_back('{tx_byte: reply[i], last_byte: 1'b0});
            end
            reply_bytes_due.push_back('{tx_byte: c[7:0], last_byte: 1'b0});
            reply_bytes_due.push_back('{tx_byte: c[15:8], last_byte: 1'b1});
            rx_phase = PH_ADDR;
         end
         default: rx_phase = PH_FUNC;
      endcase
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] pick_start();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return 16'($urandom_range(0, REG_COUNT + 1));
      if (r < 90)
         return 16'($urandom_range(0, 16'hFFFF));
      return 16'hFFFF;
   endfunction

   function automatic logic [15:0] pick_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return 16'($urandom_range(0, REG_COUNT + 1));
      if (r < 85)
         return 16'($urandom_range(0, 16'hFFFF));
      return 16'hFFFF;
   endfunction

   task automatic queue_byte(logic [7:0] b, logic [7:0] temp);
      send_queue.push_back('{rx_byte: b, temperature: temp});
      beats_queued++;
   endtask

   // full or truncated frame; temp rides on the closing crc byte
   task automatic queue_frame(logic [7:0] fn, logic [15:0] start, logic [15:0] operand,
                              bit corrupt, int keep, logic [7:0] temp);
      logic [7:0]  frame [8];
      logic [15:0] c;
      frame[0] = 8'($urandom_range(0, 255));
      frame[1] = fn;
      frame[2] = start[15:8];
      frame[3] = start[7:0];
      frame[4] = operand[15:8];
      frame[5] = operand[7:0];
      c = CRC_INIT;
      for (int i = 0; i < 6; i++)
         c = crc16_update(c, frame[i]);
      if (corrupt)
         c ^= 16'($urandom_range(1, 16'hFFFF));
      frame[6] = c[7:0];
      frame[7] = c[15:8];
      for (int i = 0; i < keep; i++)
         queue_byte(frame[i], (i == 7) ? temp : 8'($urandom_range(0, 255)));
   endtask

   task automatic queue_random_traffic(int n);
      int         first;
      int         sel;
      logic [7:0] fn;
      first = beats_queued;
      while (beats_queued - first < n) begin
         sel = $urandom_range(0, 99);
         if (sel < 5) begin
            queue_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end else if (sel < 12) begin
            queue_byte(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            do fn = 8'($urandom_range(0, 255)); while (fn == FN_READ || fn == FN_WRITE);
            queue_byte(fn, 8'($urandom_range(0, 255)));
         end else begin
            fn = $urandom_range(0, 1) ? FN_READ : FN_WRITE;
            queue_frame(fn, pick_start(),
                        (fn == FN_READ) ? pick_count() : 16'($urandom_range(0, 16'hFFFF)),
                        $urandom_range(0, 99) < 15,
                        (sel < 18) ? $urandom_range(1, 7) : 8,
                        8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic wait_idle();
      while (beats_accepted != beats_queued || reply_bytes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reply_address(logic [7:0] v);
      wait_idle();
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      reply_addr = v;
      n_settings++;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         req_pending = req_valid && !req_ready;
         if (req_valid && req_ready) begin
            absorb_request(req_data);
            beats_accepted++;
         end
         if (!req_pending) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (send_queue.size() > 0) begin
               req_data  <= send_queue.pop_front();
               req_valid <= 1'b1;
               gap_left = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_rsp_beats++;
            if (reply_bytes_due.size() == 0) begin
               flag_error($sformatf("unexpected response beat tx_byte %02h", rsp_data.tx_byte));
            end else begin
               want_beat = reply_bytes_due.pop_front();
               if (rsp_data.tx_byte !== want_beat.tx_byte)
                  flag_error($sformatf("tx_byte %02h, wanted %02h",
                                       rsp_data.tx_byte, want_beat.tx_byte));
               if (rsp_data.last_byte !== want_beat.last_byte)
                  flag_error($sformatf("last_byte %b, wanted %b on tx_byte %02h",
                                       rsp_data.last_byte, want_beat.last_byte,
                                       want_beat.tx_byte));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) < 20)
               stall_left = pick_gap();
         end
      end
   end

   // watchdog on cycles with no beat moving anywhere
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < REG_COUNT; i++)
         holding[i] = 16'h0000;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed frames at the reset reply address
      queue_frame(FN_WRITE, TEMP_REG, 16'hFFFF, 1'b0, 8, 8'h00);
      queue_frame(FN_READ, 16'h0000, 16'hFFFF, 1'b0, 8, 8'hFF);
      queue_frame(FN_WRITE, 16'hFFFF, 16'h0000, 1'b1, 8, 8'h00);
      queue_byte(8'hFF, 8'hFF);
      queue_byte(8'hFF, 8'h00);
      queue_random_traffic(75);

      write_reply_address(8'hFF);
      queue_random_traffic(75);

      write_reply_address(8'h00);
      steady = 1'b1;
      queue_random_traffic(75);

      write_reply_address(8'($urandom_range(1, 254)));
      steady = 1'b0;
      queue_random_traffic(75);

      wait_idle();
      $display("covered %0d request beats and %0d response beats (%0d read, %0d write replies)",
               beats_accepted, n_rsp_beats, n_read_replies, n_write_replies);
      $display("reply address rewritten %0d times, %0d mismatches", n_settings, errors);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
src/mbrtu_pkg.sv
src/mbrtu_crc.sv
src/modbus_rtu_register_slave_unit.sv
tb/sv/tb_modbus_rtu_register_slave_unit.sv
